// ===== design/nrmc_pkg.sv =====
package nrmc_pkg;

  // line buffer limit, bytes past MAX_LINE-1 in one line are dropped
  localparam int MAX_LINE = 128;
  localparam int LEN_W    = $clog2(MAX_LINE);

  // result widths
  localparam int LAT_W = 27;
  localparam int LON_W = 31;
  localparam int MIN_W = 20;
  localparam int TIM_W = 7;
  localparam int LATD_W = 7;
  localparam int LOND_W = 10;

  // fixed point scale: 1 degree = 600000, 1 minute = 10000
  localparam logic [19:0] DEG_SCALE = 20'd600000;
  localparam logic [23:0] MIN_UNIT  = 24'd10000;
  localparam logic [23:0] MIN_CAP   = 24'd990000;

  // characters of interest
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_DOT   = 8'd46;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_A     = 8'd65;
  localparam logic [7:0] CHAR_S     = 8'd83;
  localparam logic [7:0] CHAR_W     = 8'd87;

  // field positions in an RMC line
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_MAX    = 4'd15;
  localparam logic [6:0] CIF_MAX    = 7'd127;
  localparam logic [3:0] NOT_DIGIT  = 4'd10;

  // weights of the four kept minute fraction digits
  localparam logic [9:0] FRAC_WEIGHT [4] = '{10'd1000, 10'd100, 10'd10, 10'd1};

  // accumulated content of one line
  typedef struct packed {
    logic              status;
    logic [TIM_W-1:0]  hours;
    logic [TIM_W-1:0]  minutes;
    logic [TIM_W-1:0]  seconds;
    logic [LATD_W-1:0] lat_deg;
    logic [MIN_W-1:0]  lat_min;
    logic [LOND_W-1:0] lon_deg;
    logic [MIN_W-1:0]  lon_min;
    logic              south;
    logic              west;
  } line_t;

  typedef struct packed {
    logic [LOND_W-1:0] acc;
    logic              stopped;
  } plain_t;

  typedef struct packed {
    logic [MIN_W-1:0] acc;
    logic             stopped;
    logic [2:0]       frac;
  } min_step_t;

  function automatic logic [3:0] digit_value(logic [7:0] c);
    logic [7:0] diff;
    diff = c - CHAR_ZERO;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return diff[3:0];
    end
    return NOT_DIGIT;
  endfunction

  // decimal digit group, stops at the first non-digit
  function automatic plain_t plain_step(logic [LOND_W-1:0] acc, logic [3:0] d,
                                        logic restart, logic stopped);
    plain_t r;
    r.acc     = acc;
    r.stopped = restart ? 1'b0 : stopped;
    if (!r.stopped) begin
      if (d < NOT_DIGIT) begin
        r.acc = LOND_W'(acc * LOND_W'(10) + LOND_W'(d));
      end else begin
        r.stopped = 1'b1;
      end
    end
    return r;
  endfunction

  // minutes: integer digits, one dot, up to four kept fraction digits
  function automatic min_step_t minutes_step(logic [MIN_W-1:0] acc, logic [7:0] c,
                                             logic [3:0] d, logic restart,
                                             logic stopped, logic [2:0] frac);
    min_step_t   r;
    logic [23:0] v;
    logic [13:0] part;
    logic [2:0]  widx;
    r.acc     = acc;
    r.stopped = restart ? 1'b0 : stopped;
    r.frac    = restart ? 3'd0 : frac;
    v         = 24'(acc) * 24'd10 + 24'(d) * MIN_UNIT;
    widx      = r.frac - 3'd1;
    part      = 14'(d) * 14'(FRAC_WEIGHT[widx[1:0]]);
    if (!r.stopped) begin
      if (r.frac == 3'd0) begin
        if (d < NOT_DIGIT) begin
          r.acc = (v > MIN_CAP) ? MIN_W'(MIN_CAP) : v[MIN_W-1:0];
        end else if (c == CHAR_DOT) begin
          r.frac = 3'd1;
        end else begin
          r.stopped = 1'b1;
        end
      end else begin
        if (d < NOT_DIGIT) begin
          if (r.frac <= 3'd4) begin
            r.acc = acc + MIN_W'(part);
          end
          if (r.frac < 3'd5) begin
            r.frac = r.frac + 3'd1;
          end
        end else begin
          r.stopped = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== design/nmea_rmc_sentence_parser_core.sv =====
// NMEA RMC line parser. Takes one received byte per beat, one beat per cycle, and
// splits the line into comma-separated fields on the fly. A newline byte produces one
// result beat (fix flag, UTC hh/mm/ss, signed latitude and longitude in 1/600000
// degree) that shows up on the output in the cycle after the newline is taken. The result
// sits in a single output register: the input is only stalled while that register is
// full and the output side is stalling, so with a free-running sink the block takes a
// byte every cycle. The per-byte field update and the degree scaling are each one
// register stage deep. Checksum and sentence type are not checked.
module nmea_rmc_sentence_parser_core import nrmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              rx_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    fix_valid_o,
  output logic [TIM_W-1:0]        utc_hours_o,
  output logic [TIM_W-1:0]        utc_minutes_o,
  output logic [TIM_W-1:0]        utc_seconds_o,
  output logic signed [LAT_W-1:0] latitude_o,
  output logic signed [LON_W-1:0] longitude_o
);

  logic             beat;
  logic             nl_beat;
  line_t            line;
  logic [LAT_W-1:0] lat_abs;
  logic [LON_W-1:0] lon_abs;

  logic             out_valid_q, out_valid_d;
  logic             fix_q;
  logic [TIM_W-1:0] hours_q, minutes_q, seconds_q;
  logic [LAT_W-1:0] lat_q, lat_d;
  logic [LON_W-1:0] lon_q, lon_d;

  // handshake
  assign in_stall_o = out_valid_q & out_stall_i;
  assign beat       = in_valid_i & ~in_stall_o;
  assign nl_beat    = beat & (rx_byte_i == CHAR_NL);

  nrmc_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .line_o    (line)
  );

  // degrees to fixed point plus minutes, then hemisphere sign
  assign lat_abs = LAT_W'(LAT_W'(line.lat_deg) * LAT_W'(DEG_SCALE)) + LAT_W'(line.lat_min);
  assign lon_abs = LON_W'(LON_W'(line.lon_deg) * LON_W'(DEG_SCALE)) + LON_W'(line.lon_min);
  assign lat_d   = line.south ? (LAT_W'(0) - lat_abs) : lat_abs;
  assign lon_d   = line.west ? (LON_W'(0) - lon_abs) : lon_abs;

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (nl_beat) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (nl_beat) begin
      fix_q     <= line.status;
      hours_q   <= line.hours;
      minutes_q <= line.minutes;
      seconds_q <= line.seconds;
      lat_q     <= lat_d;
      lon_q     <= lon_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fix_valid_o   = fix_q;
  assign utc_hours_o   = hours_q;
  assign utc_minutes_o = minutes_q;
  assign utc_seconds_o = seconds_q;
  assign latitude_o    = $signed(lat_q);
  assign longitude_o   = $signed(lon_q);

  // a taken newline always leaves a result beat waiting
  a_nl_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_beat |=> out_valid_o)
    else $error("newline beat produced no result");

  // a taken newline clears the line state for the next line
  a_nl_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_beat |=> (line.hours == '0 && line.lat_min == '0 && line.lon_deg == '0 &&
                 line.south == 1'b0 && line.west == 1'b0 && line.status == 1'b0))
    else $error("line state not cleared after newline");

  // a drained result is not shown again without a new newline
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !nl_beat) |=> !out_valid_o)
    else $error("result beat repeated");

endmodule

// ===== design/nrmc_parse.sv =====
module nrmc_parse import nrmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] rx_byte_i,
  output line_t      line_o
);

  line_t            line_q, line_d;
  logic [3:0]       field_q, field_d;
  logic [6:0]       cif_q, cif_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [2:0]       frac_q, frac_d;
  logic             stop_q, stop_d;

  logic [3:0]       dig;
  plain_t           ps;
  min_step_t        ms;

  assign dig    = digit_value(rx_byte_i);
  assign line_o = line_q;

  // per-byte field tracking and accumulation
  always_comb begin
    line_d  = line_q;
    field_d = field_q;
    cif_d   = cif_q;
    len_d   = len_q;
    frac_d  = frac_q;
    stop_d  = stop_q;
    ps      = '0;
    ms      = '0;
    if (beat_i) begin
      if (rx_byte_i == CHAR_NL) begin
        line_d  = '0;
        field_d = '0;
        cif_d   = '0;
        len_d   = '0;
        frac_d  = '0;
        stop_d  = 1'b0;
      end else if (len_q < LEN_W'(MAX_LINE - 1)) begin
        len_d = len_q + LEN_W'(1);
        if (rx_byte_i == CHAR_COMMA) begin
          if (field_q < FLD_MAX) begin
            field_d = field_q + 4'd1;
          end
          cif_d  = '0;
          stop_d = 1'b0;
          frac_d = '0;
        end else begin
          unique case (field_q)
            FLD_TIME: begin
              if (cif_q < 7'd2) begin
                ps = plain_step(LOND_W'(line_q.hours), dig, cif_q == 7'd0, stop_q);
                line_d.hours = ps.acc[TIM_W-1:0];
                stop_d = ps.stopped;
              end else if (cif_q < 7'd4) begin
                ps = plain_step(LOND_W'(line_q.minutes), dig, cif_q == 7'd2, stop_q);
                line_d.minutes = ps.acc[TIM_W-1:0];
                stop_d = ps.stopped;
              end else if (cif_q < 7'd6) begin
                ps = plain_step(LOND_W'(line_q.seconds), dig, cif_q == 7'd4, stop_q);
                line_d.seconds = ps.acc[TIM_W-1:0];
                stop_d = ps.stopped;
              end
            end
            FLD_STATUS: begin
              if (cif_q == 7'd0) begin
                line_d.status = (rx_byte_i == CHAR_A);
              end
            end
            FLD_LAT: begin
              if (cif_q < 7'd2) begin
                ps = plain_step(LOND_W'(line_q.lat_deg), dig, cif_q == 7'd0, stop_q);
                line_d.lat_deg = ps.acc[LATD_W-1:0];
                stop_d = ps.stopped;
              end else begin
                ms = minutes_step(line_q.lat_min, rx_byte_i, dig, cif_q == 7'd2,
                                  stop_q, frac_q);
                line_d.lat_min = ms.acc;
                stop_d = ms.stopped;
                frac_d = ms.frac;
              end
            end
            FLD_NS: begin
              if (cif_q == 7'd0) begin
                line_d.south = (rx_byte_i == CHAR_S);
              end
            end
            FLD_LON: begin
              if (cif_q < 7'd3) begin
                ps = plain_step(line_q.lon_deg, dig, cif_q == 7'd0, stop_q);
                line_d.lon_deg = ps.acc;
                stop_d = ps.stopped;
              end else begin
                ms = minutes_step(line_q.lon_min, rx_byte_i, dig, cif_q == 7'd3,
                                  stop_q, frac_q);
                line_d.lon_min = ms.acc;
                stop_d = ms.stopped;
                frac_d = ms.frac;
              end
            end
            FLD_EW: begin
              if (cif_q == 7'd0) begin
                line_d.west = (rx_byte_i == CHAR_W);
              end
            end
            default: begin
            end
          endcase
          if (cif_q < CIF_MAX) begin
            cif_d = cif_q + 7'd1;
          end
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      field_q <= '0;
      cif_q   <= '0;
      len_q   <= '0;
      frac_q  <= '0;
      stop_q  <= 1'b0;
    end else begin
      line_q  <= line_d;
      field_q <= field_d;
      cif_q   <= cif_d;
      len_q   <= len_d;
      frac_q  <= frac_d;
      stop_q  <= stop_d;
    end
  end

endmodule
